>>> rtl/core/ssdd_pkg.sv
// Shared types, constants and helpers of the spreadsheet serial date decoder.
// Used by the control store, the datapath and the top level; no dependencies.
package ssdd_pkg;

  localparam int SerialW = 23;
  localparam int DremW   = 22;
  localparam int YearW   = 14;
  localparam int PcW     = 4;

  localparam logic signed [SerialW-1:0] SERIAL_MIN = -23'sd693000;
  localparam logic signed [SerialW-1:0] SERIAL_MAX = 23'sd2958465;
  localparam logic [YearW-1:0]          YEAR_MAX   = 14'd9999;
  localparam logic [YearW-1:0]          YEAR_QUIRK = 14'd1900;

  // microcode step addresses
  localparam logic [PcW-1:0] STEP_WAIT   = 4'd0;
  localparam logic [PcW-1:0] STEP_INIT   = 4'd1;
  localparam logic [PcW-1:0] STEP_SIGN   = 4'd2;
  localparam logic [PcW-1:0] STEP_NYEAR  = 4'd3;
  localparam logic [PcW-1:0] STEP_NMONTH = 4'd4;
  localparam logic [PcW-1:0] STEP_NJOIN  = 4'd5;
  localparam logic [PcW-1:0] STEP_PYEAR  = 4'd6;
  localparam logic [PcW-1:0] STEP_PMONTH = 4'd7;
  localparam logic [PcW-1:0] STEP_RANGE  = 4'd8;
  localparam logic [PcW-1:0] STEP_EMIT   = 4'd9;
  localparam logic [PcW-1:0] STEP_LOOP   = 4'd10;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_LOAD   = 3'd1,
    OP_INIT   = 3'd2,
    OP_NYEAR  = 3'd3,
    OP_NMONTH = 3'd4,
    OP_PYEAR  = 3'd5,
    OP_PMONTH = 3'd6,
    OP_RANGE  = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NO_IN    = 4'd2,
    C_SPECIAL  = 4'd3,
    C_POS      = 4'd4,
    C_PYSTEP   = 4'd5,
    C_PMSTEP   = 4'd6,
    C_NYSTEP   = 4'd7,
    C_NMSTEP   = 4'd8,
    C_OUT_BUSY = 4'd9
  } cond_t;

  typedef struct packed {
    op_t            op;
    logic           emit;
    cond_t          cond;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic special;  // out of range or serial zero: result already set
    logic pos;
    logic pystep;
    logic pmstep;
    logic nystep;
    logic nmstep;
  } dp_stat_t;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [3:0]       month;
    logic [4:0]       day;
    logic [2:0]       quarter;
    logic             range_error;
  } result_t;

  // month length, k counts from 0 (January)
  function automatic logic [4:0] month_len(input logic [3:0] k, input logic lp);
    logic [4:0] len;
    begin
      case (k)
        4'd1: begin
          len = lp ? 5'd29 : 5'd28;
        end
        4'd3, 4'd5, 4'd8, 4'd10: begin
          len = 5'd30;
        end
        default: begin
          len = 5'd31;
        end
      endcase
      return len;
    end
  endfunction

  function automatic logic [2:0] quarter_of(input logic [3:0] m);
    logic [2:0] q;
    begin
      case (m) inside
        [4'd1:4'd3]:   q = 3'd1;
        [4'd4:4'd6]:   q = 3'd2;
        [4'd7:4'd9]:   q = 3'd3;
        [4'd10:4'd12]: q = 3'd4;
        default:       q = 3'd0;
      endcase
      return q;
    end
  endfunction

endpackage

>>> rtl/core/ssdd_urom.sv
// Control store of the serial date decoder: one control word per step.
// Depends on ssdd_pkg.
module ssdd_urom import ssdd_pkg::*; (
  input  logic [PcW-1:0] pc,
  output uword_t         uw
);

  always_comb begin
    case (pc)
      STEP_WAIT:   uw = '{op: OP_LOAD,   emit: 1'b0, cond: C_NO_IN,    target: STEP_WAIT};
      STEP_INIT:   uw = '{op: OP_INIT,   emit: 1'b0, cond: C_SPECIAL,  target: STEP_EMIT};
      STEP_SIGN:   uw = '{op: OP_NOP,    emit: 1'b0, cond: C_POS,      target: STEP_PYEAR};
      STEP_NYEAR:  uw = '{op: OP_NYEAR,  emit: 1'b0, cond: C_NYSTEP,   target: STEP_NYEAR};
      STEP_NMONTH: uw = '{op: OP_NMONTH, emit: 1'b0, cond: C_NMSTEP,   target: STEP_NMONTH};
      STEP_NJOIN:  uw = '{op: OP_NOP,    emit: 1'b0, cond: C_ALWAYS,   target: STEP_RANGE};
      STEP_PYEAR:  uw = '{op: OP_PYEAR,  emit: 1'b0, cond: C_PYSTEP,   target: STEP_PYEAR};
      STEP_PMONTH: uw = '{op: OP_PMONTH, emit: 1'b0, cond: C_PMSTEP,   target: STEP_PMONTH};
      STEP_RANGE:  uw = '{op: OP_RANGE,  emit: 1'b0, cond: C_NEVER,    target: STEP_WAIT};
      STEP_EMIT:   uw = '{op: OP_NOP,    emit: 1'b1, cond: C_OUT_BUSY, target: STEP_EMIT};
      STEP_LOOP:   uw = '{op: OP_NOP,    emit: 1'b0, cond: C_ALWAYS,   target: STEP_WAIT};
      default:     uw = '{op: OP_NOP,    emit: 1'b0, cond: C_ALWAYS,   target: STEP_WAIT};
    endcase
  end

endmodule

>>> rtl/core/ssdd_dpath.sv
// Datapath of the serial date decoder: day remainder, year and month walk.
// Depends on ssdd_pkg; driven by control words from ssdd_urom.
module ssdd_dpath import ssdd_pkg::*; (
  input  logic                      clk,
  input  op_t                       op,
  input  logic                      in_fire,
  input  logic signed [SerialW-1:0] serial,
  input  logic                      base_1904,
  output dp_stat_t                  stat,
  output result_t                   res
);

  logic signed [SerialW-1:0] serial_r, serial_nxt;
  logic [DremW-1:0]          drem_r, drem_nxt;
  logic [YearW-1:0]          y_r, y_nxt;
  logic [6:0]                c100_r, c100_nxt;   // year mod 100
  logic [8:0]                c400_r, c400_nxt;   // year mod 400
  logic [3:0]                k_r, k_nxt;
  logic [3:0]                m_r, m_nxt;
  logic [4:0]                d_r, d_nxt;
  logic                      err_r, err_nxt;

  logic                      oor_w, zero_w, neg_w, leap_w, quirk_w, lp_p_w;
  logic [8:0]                yd_p_w, yd_n_w;
  logic [4:0]                md_p_w, md_n_w;
  logic [SerialW-1:0]        mag_w;

  assign oor_w   = (serial_r < SERIAL_MIN) || (serial_r > SERIAL_MAX);
  assign zero_w  = (serial_r == '0);
  assign neg_w   = serial_r[SerialW-1];
  assign mag_w   = SerialW'(-serial_r);
  assign leap_w  = ((y_r[1:0] == 2'd0) && (c100_r != 7'd0)) || (c400_r == 9'd0);
  assign quirk_w = (y_r == YEAR_QUIRK);
  assign lp_p_w  = leap_w || quirk_w;
  assign yd_p_w  = 9'd365 + {8'd0, leap_w} + {8'd0, quirk_w};
  assign yd_n_w  = 9'd365 + {8'd0, leap_w};
  assign md_p_w  = month_len(k_r, lp_p_w);
  assign md_n_w  = month_len(k_r, leap_w);

  always_comb begin
    stat.special = oor_w || zero_w;
    stat.pos     = !neg_w;
    stat.pystep  = drem_r > {13'd0, yd_p_w};
    stat.pmstep  = (drem_r > {17'd0, md_p_w}) && (k_r != 4'd11);
    stat.nystep  = (drem_r >= {13'd0, yd_n_w}) && (y_r > 14'd1);
    stat.nmstep  = (drem_r >= {17'd0, md_n_w}) && (k_r != 4'd0);
  end

  always_comb begin
    serial_nxt = serial_r;
    drem_nxt   = drem_r;
    y_nxt      = y_r;
    c100_nxt   = c100_r;
    c400_nxt   = c400_r;
    k_nxt      = k_r;
    m_nxt      = m_r;
    d_nxt      = d_r;
    err_nxt    = err_r;
    case (op)
      OP_LOAD: begin
        if (in_fire) begin
          serial_nxt = serial;
        end
      end
      OP_INIT: begin
        err_nxt = 1'b0;
        if (oor_w) begin
          err_nxt = 1'b1;
          y_nxt   = '0;
          m_nxt   = '0;
          d_nxt   = '0;
        end else if (zero_w) begin
          y_nxt = base_1904 ? 14'd1904 : 14'd1899;
          m_nxt = base_1904 ? 4'd1 : 4'd12;
          d_nxt = base_1904 ? 5'd1 : 5'd31;
        end else if (neg_w) begin
          // walk back from the year before the base
          drem_nxt = mag_w[DremW-1:0] - {{(DremW-1){1'b0}}, base_1904};
          y_nxt    = base_1904 ? 14'd1903 : 14'd1899;
          c100_nxt = base_1904 ? 7'd3 : 7'd99;
          c400_nxt = base_1904 ? 9'd303 : 9'd299;
          k_nxt    = 4'd11;
          m_nxt    = 4'd1;
          d_nxt    = 5'd1;
        end else begin
          drem_nxt = serial_r[DremW-1:0] + {{(DremW-1){1'b0}}, base_1904};
          y_nxt    = base_1904 ? 14'd1904 : 14'd1900;
          c100_nxt = base_1904 ? 7'd4 : 7'd0;
          c400_nxt = base_1904 ? 9'd304 : 9'd300;
          k_nxt    = 4'd0;
          m_nxt    = 4'd12;
          d_nxt    = 5'd31;
        end
      end
      OP_PYEAR: begin
        if (stat.pystep) begin
          drem_nxt = drem_r - {13'd0, yd_p_w};
          y_nxt    = y_r + 14'd1;
          c100_nxt = (c100_r == 7'd99) ? 7'd0 : c100_r + 7'd1;
          c400_nxt = (c400_r == 9'd399) ? 9'd0 : c400_r + 9'd1;
        end
      end
      OP_PMONTH: begin
        if (drem_r > {17'd0, md_p_w}) begin
          drem_nxt = drem_r - {17'd0, md_p_w};
          k_nxt    = k_r + 4'd1;
        end else begin
          m_nxt = k_r + 4'd1;
          d_nxt = drem_r[4:0];
        end
      end
      OP_NYEAR: begin
        if (stat.nystep) begin
          drem_nxt = drem_r - {13'd0, yd_n_w};
          y_nxt    = y_r - 14'd1;
          c100_nxt = (c100_r == 7'd0) ? 7'd99 : c100_r - 7'd1;
          c400_nxt = (c400_r == 9'd0) ? 9'd399 : c400_r - 9'd1;
        end
      end
      OP_NMONTH: begin
        // January overflow keeps the preset first of January
        if (drem_r >= {17'd0, md_n_w}) begin
          drem_nxt = drem_r - {17'd0, md_n_w};
          if (k_r != 4'd0) begin
            k_nxt = k_r - 4'd1;
          end
        end else begin
          m_nxt = k_r + 4'd1;
          d_nxt = md_n_w - drem_r[4:0];
        end
      end
      OP_RANGE: begin
        if (y_r > YEAR_MAX) begin
          err_nxt = 1'b1;
          y_nxt   = '0;
          m_nxt   = '0;
          d_nxt   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    serial_r <= serial_nxt;
    drem_r   <= drem_nxt;
    y_r      <= y_nxt;
    c100_r   <= c100_nxt;
    c400_r   <= c400_nxt;
    k_r      <= k_nxt;
    m_r      <= m_nxt;
    d_r      <= d_nxt;
    err_r    <= err_nxt;
  end

  always_comb begin
    res.year        = y_r;
    res.month       = m_r;
    res.day         = d_r;
    res.quarter     = err_r ? 3'd0 : quarter_of(m_r);
    res.range_error = err_r;
  end

endmodule

>>> rtl/core/spreadsheet_serial_date_decode.sv
// Top level of the spreadsheet serial date decoder: step counter, handshakes,
// configuration register and result register. Depends on ssdd_pkg, ssdd_urom, ssdd_dpath.
//
// Decodes a signed day serial into year, month, day and quarter, counted
// from 1899-12-31 (with the false 1900 leap day) or from 1904-01-01 when
// base_1904 is set. One word is decoded at a time. A small microprogram
// steps a shared subtract-and-compare datapath: one year per cycle through
// the year walk, then one month per cycle. Serial zero and out-of-range
// serials skip both walks. The year walk dominates the decode time for a
// word far from the base. Serials below -693000 or above 2958465, or dates
// past year 9999, give range_error with the other fields zero. A finished
// result waits in the output register while the next input word is already
// taken. Write base_1904 only while the block is idle.
module spreadsheet_serial_date_decode import ssdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [22:0] serial_day (signed), [23] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [13:0] year, [17:14] month, [22:18] day,
                                   // [25:23] quarter, [26] range_error, [31:27] zero
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data     // base_1904
);

  logic [PcW-1:0] pc_r, pc_nxt;
  logic           base_r, base_nxt;
  logic           out_valid_r, out_valid_nxt;
  result_t        out_res_r, out_res_nxt;

  uword_t         uw;
  dp_stat_t       stat;
  result_t        res;
  logic           in_fire, out_free, load_out, jump;

  ssdd_urom u_urom (
    .pc (pc_r),
    .uw (uw)
  );

  ssdd_dpath u_dpath (
    .clk       (clk),
    .op        (uw.op),
    .in_fire   (in_fire),
    .serial    (in_tdata[SerialW-1:0]),
    .base_1904 (base_r),
    .stat      (stat),
    .res       (res)
  );

  // take a word only at the wait step
  assign in_tready = (pc_r == STEP_WAIT);
  assign in_fire   = in_tready && in_tvalid;
  assign cfg_ready = 1'b1;

  assign out_free = !out_valid_r || out_tready;
  assign load_out = uw.emit && out_free;

  // branch conditions of the microprogram
  always_comb begin
    case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_IN:    jump = !in_tvalid;
      C_SPECIAL:  jump = stat.special;
      C_POS:      jump = stat.pos;
      C_PYSTEP:   jump = stat.pystep;
      C_PMSTEP:   jump = stat.pmstep;
      C_NYSTEP:   jump = stat.nystep;
      C_NMSTEP:   jump = stat.nmstep;
      C_OUT_BUSY: jump = !out_free;
      default:    jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = jump ? uw.target : pc_r + 4'd1;
  end

  // hold the result until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    base_nxt = base_r;
    if (cfg_valid && cfg_ready) begin
      base_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_WAIT;
      base_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.range_error, out_res_r.quarter, out_res_r.day,
                       out_res_r.month, out_res_r.year};

endmodule
